FILE: rtl/cau_pkg.sv
package cau_pkg;

    localparam int FRAC_BITS = 8;

    localparam int OP_W   = 16;
    localparam int LIN_W  = OP_W + 1;
    localparam int PROD_W = 2 * OP_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int RES_W  = 24;
    localparam int MAG_W  = 23;
    localparam int SQ_W   = 2 * RES_W;
    localparam int ROOT_W = SQ_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int N_CELLS = ROOT_W;

    localparam int LIMIT = (9999 << FRAC_BITS) / 100;
    localparam logic signed [OP_W-1:0] LIMIT_POS =
        (LIMIT > 32767) ? 16'sh7FFF : OP_W'(LIMIT);
    localparam logic signed [OP_W-1:0] LIMIT_NEG =
        (LIMIT > 32767) ? 16'sh8000 : OP_W'(-LIMIT);

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_SUB  = 2'd1;
    localparam logic [1:0] MODE_MUL  = 2'd2;
    localparam logic [1:0] MODE_PASS = 2'd3;

    typedef struct packed {
        logic signed [RES_W-1:0] re;
        logic signed [RES_W-1:0] im;
        logic [SQ_W-1:0]         rad;
        logic [REM_W-1:0]        rem;
        logic [ROOT_W-1:0]       root;
    } cau_cell_t;

endpackage

FILE: rtl/cau_front.sv
module cau_front
    import cau_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   vld_in,
    input  logic [1:0]             mode,
    input  logic signed [OP_W-1:0] a_real,
    input  logic signed [OP_W-1:0] a_imag,
    input  logic signed [OP_W-1:0] b_real,
    input  logic signed [OP_W-1:0] b_imag,
    output logic                   vld_out,
    output cau_cell_t              d_out
);

    localparam logic signed [ACC_W-1:0] RES_MAX = ACC_W'(2 ** (RES_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] RES_MIN = -ACC_W'(2 ** (RES_W - 1));

    function automatic logic signed [OP_W-1:0] clamp_op(input logic signed [OP_W-1:0] v);
        logic signed [OP_W-1:0] r;
        if (v > LIMIT_POS)
            r = LIMIT_POS;
        else if (v < LIMIT_NEG)
            r = LIMIT_NEG;
        else
            r = v;
        return r;
    endfunction

    function automatic logic signed [RES_W-1:0] sat_res(input logic signed [ACC_W-1:0] v);
        logic signed [RES_W-1:0] r;
        if (v > RES_MAX)
            r = RES_MAX[RES_W-1:0];
        else if (v < RES_MIN)
            r = RES_MIN[RES_W-1:0];
        else
            r = v[RES_W-1:0];
        return r;
    endfunction

    logic [4:0] vld_reg;

    logic [1:0]             mode1_reg;
    logic signed [OP_W-1:0] ar_reg, ai_reg, br_reg, bi_reg;

    logic                     mul2_reg;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [LIN_W-1:0]  lin_re_reg, lin_im_reg;

    logic signed [ACC_W-1:0] acc_re, acc_im;
    logic signed [RES_W-1:0] re_next, im_next;
    logic signed [RES_W-1:0] re3_reg, im3_reg;

    logic signed [RES_W-1:0] re4_reg, im4_reg;
    logic signed [SQ_W-1:0]  sq_re_reg, sq_im_reg;

    logic signed [LIN_W-1:0] lin_re_next, lin_im_next;

    always_comb
    begin
        case (mode1_reg)
            MODE_ADD:
            begin
                lin_re_next = LIN_W'(ar_reg) + LIN_W'(br_reg);
                lin_im_next = LIN_W'(ai_reg) + LIN_W'(bi_reg);
            end
            MODE_SUB:
            begin
                lin_re_next = LIN_W'(ar_reg) - LIN_W'(br_reg);
                lin_im_next = LIN_W'(ai_reg) - LIN_W'(bi_reg);
            end
            default:
            begin
                lin_re_next = LIN_W'(ar_reg);
                lin_im_next = LIN_W'(ai_reg);
            end
        endcase
    end

    always_comb
    begin
        if (mul2_reg)
        begin
            acc_re = (ACC_W'(p_rr_reg) - ACC_W'(p_ii_reg)) >>> FRAC_BITS;
            acc_im = (ACC_W'(p_ri_reg) + ACC_W'(p_ir_reg)) >>> FRAC_BITS;
        end
        else
        begin
            acc_re = ACC_W'(lin_re_reg);
            acc_im = ACC_W'(lin_im_reg);
        end
        re_next = sat_res(acc_re);
        im_next = sat_res(acc_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], vld_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode1_reg  <= mode;
            ar_reg     <= clamp_op(a_real);
            ai_reg     <= clamp_op(a_imag);
            br_reg     <= clamp_op(b_real);
            bi_reg     <= clamp_op(b_imag);

            mul2_reg   <= (mode1_reg == MODE_MUL);
            p_rr_reg   <= ar_reg * br_reg;
            p_ii_reg   <= ai_reg * bi_reg;
            p_ri_reg   <= ar_reg * bi_reg;
            p_ir_reg   <= br_reg * ai_reg;
            lin_re_reg <= lin_re_next;
            lin_im_reg <= lin_im_next;

            re3_reg    <= re_next;
            im3_reg    <= im_next;

            re4_reg    <= re3_reg;
            im4_reg    <= im3_reg;
            sq_re_reg  <= re3_reg * re3_reg;
            sq_im_reg  <= im3_reg * im3_reg;

            d_out.re   <= re4_reg;
            d_out.im   <= im4_reg;
            d_out.rad  <= SQ_W'($unsigned(sq_re_reg)) + SQ_W'($unsigned(sq_im_reg));
            d_out.rem  <= '0;
            d_out.root <= '0;
        end
    end

    assign vld_out = vld_reg[4];

endmodule

FILE: rtl/cau_sqrt_cell.sv
module cau_sqrt_cell
    import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      vld_in,
    input  cau_cell_t d_in,
    output logic      vld_out,
    output cau_cell_t d_out
);

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;
    cau_cell_t         d_next;

    always_comb
    begin
        rem_sh = {d_in.rem[REM_W-3:0], d_in.rad[SQ_W-1 -: 2]};
        trial  = REM_W'({d_in.root, 2'b01});
        take   = (rem_sh >= trial);

        d_next.re   = d_in.re;
        d_next.im   = d_in.im;
        d_next.rad  = {d_in.rad[SQ_W-3:0], 2'b00};
        d_next.rem  = take ? (rem_sh - trial) : rem_sh;
        d_next.root = {d_in.root[ROOT_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out <= 1'b0;
        else if (en)
            vld_out <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_out <= d_next;
    end

`ifndef SYNTH
    // partial remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_out |-> (d_out.rem <= REM_W'({d_out.root, 1'b0})))
        else $error("sqrt cell remainder out of bound");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_in) |=> vld_out)
        else $error("sqrt cell dropped a word");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && vld_out) |=> (vld_out && $stable(d_out)))
        else $error("sqrt cell changed while stalled");
`endif

endmodule

FILE: rtl/complex_alu_with_magnitude_core.sv
// Complex add / subtract / multiply / pass unit with magnitude, signed Q8.
//
// Input word: s_tdata = {b_imag, b_real, a_imag, a_real}, 16 bits each,
// s_tuser = mode (add, subtract A-B, multiply, pass A). Operand parts are
// clamped to +/-99.99 before use; products are floored after rescaling.
// Output word: m_tdata = {pad, magnitude[22:0], res_imag[23:0], res_real[23:0]}.
//
// Five arithmetic stages (clamp, partial products, combine and saturate,
// squares, sum of squares) feed a chain of 24 square-root cells, one result
// bit per cell. One word is accepted per cycle unless the output stalls.
//
// Reset clears only the valid bits; the pipe is empty after reset. When the
// receiver stalls with a word on m_tdata, the whole pipe freezes and
// s_tready drops in the same cycle; nothing is lost or repeated.
module complex_alu_with_magnitude_core
    import cau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // a_real, a_imag, b_real, b_imag
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // res_real, res_imag, magnitude, zero pad
);

    localparam logic [ROOT_W-1:0] MAG_MAX = ROOT_W'(2 ** MAG_W - 1);

    logic                  en;
    logic [N_CELLS:0]      vld;
    cau_cell_t             chain [N_CELLS+1];
    logic [MAG_W-1:0]      mag;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    cau_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (s_tvalid),
        .mode    (s_tuser),
        .a_real  (s_tdata[15:0]),
        .a_imag  (s_tdata[31:16]),
        .b_real  (s_tdata[47:32]),
        .b_imag  (s_tdata[63:48]),
        .vld_out (vld[0]),
        .d_out   (chain[0])
    );

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        cau_sqrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (vld[i]),
            .d_in    (chain[i]),
            .vld_out (vld[i+1]),
            .d_out   (chain[i+1])
        );
    end

    assign mag = (chain[N_CELLS].root > MAG_MAX) ? MAG_MAX[MAG_W-1:0]
                                                  : chain[N_CELLS].root[MAG_W-1:0];

    assign m_tvalid = vld[N_CELLS];
    assign m_tdata  = {1'b0, mag, chain[N_CELLS].im, chain[N_CELLS].re};

endmodule
